@@ rtl/core/drb_pkg.sv @@
// ----------------------------------------------------------------------------
// drb_pkg
// Shared widths, constants and types of the daylight ramp brightness block.
// ----------------------------------------------------------------------------
package drb_pkg;

	// Fraction bits of the ramp progress t.
	localparam int FRAC_BITS = 16;

	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int MIN_W    = 11;
	localparam int PCT_W    = 7;
	localparam int REM_W    = MIN_W + 1;

	localparam int T_W  = FRAC_BITS;
	localparam int U_W  = FRAC_BITS + 1;
	localparam int PR_W = 2 * FRAC_BITS + 2;
	localparam int P_W  = FRAC_BITS + 9;
	localparam int Q_W  = FRAC_BITS + 7;
	localparam int X_W  = 14;

	localparam int MINUTES_PER_HOUR = 60;

	localparam logic [U_W-1:0] ONE_Q  = U_W'(1) << FRAC_BITS;
	localparam logic [Q_W-1:0] FULL_Q = Q_W'(100) << FRAC_BITS;

	// Bezier weights scaled by 100: 3*0.42, 3*0.58 and 1.
	localparam int W_RISE = 126;
	localparam int W_FALL = 174;
	localparam int W_CUBE = 100;

	// floor(x / 100) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2^14.
	localparam int RECIP_W     = 13;
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 19;

	localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

	// Configuration register indices (paddr[4:2]).
	typedef enum logic [2:0] {
		IDX_ON         = 3'd0,
		IDX_PEAK_START = 3'd1,
		IDX_PEAK_END   = 3'd2,
		IDX_OFF        = 3'd3,
		IDX_PEAK_WHITE = 3'd4,
		IDX_PEAK_BLUE  = 3'd5,
		IDX_PEAK_UV    = 3'd6
	} cfg_idx_t;

	localparam logic [MIN_W-1:0] RST_ON         = MIN_W'(480);
	localparam logic [MIN_W-1:0] RST_PEAK_START = MIN_W'(600);
	localparam logic [MIN_W-1:0] RST_PEAK_END   = MIN_W'(960);
	localparam logic [MIN_W-1:0] RST_OFF        = MIN_W'(1200);
	localparam logic [PCT_W-1:0] RST_PEAK       = PCT_W'(100);

	typedef enum logic [1:0] {
		REGION_DARK,
		REGION_PEAK,
		REGION_RISE,
		REGION_FALL
	} region_t;

	typedef struct packed {
		logic    valid;
		region_t region;
	} ctl_t;

	typedef struct packed {
		logic [MIN_W-1:0] on_min;
		logic [MIN_W-1:0] peak_start;
		logic [MIN_W-1:0] peak_end;
		logic [MIN_W-1:0] off_min;
	} sched_t;

	typedef struct packed {
		logic [PCT_W-1:0] white;
		logic [PCT_W-1:0] blue;
		logic [PCT_W-1:0] uv;
	} peaks_t;

endpackage

@@ rtl/core/drb_sched.sv @@
// ----------------------------------------------------------------------------
// drb_sched
// Minute of day and schedule region, with elapsed time and ramp length.
// ----------------------------------------------------------------------------
module drb_sched (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [drb_pkg::HOUR_W-1:0]    hour,
	input  logic [drb_pkg::MINUTE_W-1:0]  minute,
	input  drb_pkg::sched_t               sched,
	output drb_pkg::ctl_t                 ctl,
	output logic [drb_pkg::MIN_W-1:0]     elapsed,
	output logic [drb_pkg::MIN_W-1:0]     span
);
	import drb_pkg::*;

	logic             valid_s1;
	logic [MIN_W-1:0] mod_s1;
	ctl_t             ctl_s2;
	logic [MIN_W-1:0] elapsed_s2;
	logic [MIN_W-1:0] span_s2;
	region_t          region;
	logic [MIN_W-1:0] elapsed_d;
	logic [MIN_W-1:0] span_d;

	always_comb begin
		region    = REGION_DARK;
		elapsed_d = '0;
		span_d    = '0;
		if (mod_s1 < sched.on_min || mod_s1 >= sched.off_min) begin
			region = REGION_DARK;
		end else if (mod_s1 >= sched.peak_start && mod_s1 < sched.peak_end) begin
			region = REGION_PEAK;
		end else if (mod_s1 < sched.peak_start) begin
			region    = REGION_RISE;
			elapsed_d = mod_s1 - sched.on_min;
			span_d    = sched.peak_start - sched.on_min;
		end else if (mod_s1 >= sched.peak_end) begin
			region    = REGION_FALL;
			elapsed_d = mod_s1 - sched.peak_end;
			span_d    = sched.off_min - sched.peak_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			ctl_s2.valid  <= 1'b0;
			ctl_s2.region <= REGION_DARK;
		end else if (en) begin
			valid_s1      <= in_valid;
			ctl_s2.valid  <= valid_s1;
			ctl_s2.region <= region;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mod_s1 <= MIN_W'(hour) * MIN_W'(MINUTES_PER_HOUR) + MIN_W'(minute);
			elapsed_s2    <= elapsed_d;
			span_s2       <= span_d;
		end
	end

	assign ctl     = ctl_s2;
	assign elapsed = elapsed_s2;
	assign span    = span_s2;

endmodule

@@ rtl/core/drb_div.sv @@
// ----------------------------------------------------------------------------
// drb_div
// Pipelined restoring divider: t = floor(elapsed * 2^FRAC_BITS / span).
// ----------------------------------------------------------------------------
module drb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  drb_pkg::ctl_t              ctl_in,
	input  logic [drb_pkg::MIN_W-1:0]  elapsed,
	input  logic [drb_pkg::MIN_W-1:0]  span,
	output drb_pkg::ctl_t              ctl_out,
	output logic [drb_pkg::T_W-1:0]    quot
);
	import drb_pkg::*;

	// One quotient bit per stage. Elapsed is below span on a ramp, so the
	// integer part of the quotient is zero and the partial remainder fits.
	ctl_t             ctl_s   [FRAC_BITS];
	logic [MIN_W-1:0] rem_s   [FRAC_BITS];
	logic [MIN_W-1:0] span_s  [FRAC_BITS];
	logic [T_W-1:0]   quot_s  [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
		ctl_t             src_ctl;
		logic [MIN_W-1:0] src_rem;
		logic [MIN_W-1:0] src_span;
		logic [T_W-1:0]   src_quot;
		logic [REM_W-1:0] twice;
		logic             fits;

		if (k == 0) begin : g_first
			assign src_ctl  = ctl_in;
			assign src_rem  = elapsed;
			assign src_span = span;
			assign src_quot = '0;
		end else begin : g_next
			assign src_ctl  = ctl_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_span = span_s[k-1];
			assign src_quot = quot_s[k-1];
		end

		assign twice = {src_rem, 1'b0};
		assign fits  = twice >= {1'b0, src_span};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k].valid  <= 1'b0;
				ctl_s[k].region <= REGION_DARK;
			end else if (en) begin
				ctl_s[k].valid  <= src_ctl.valid;
				ctl_s[k].region <= src_ctl.region;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				span_s[k]       <= src_span;
				rem_s[k]        <= fits ? MIN_W'(twice - {1'b0, src_span})
				                        : MIN_W'(twice);
				quot_s[k]       <= {src_quot[T_W-2:0], fits};
			end
		end
	end

	assign ctl_out = ctl_s[FRAC_BITS-1];
	assign quot    = quot_s[FRAC_BITS-1];

endmodule

@@ rtl/core/drb_ease.sv @@
// ----------------------------------------------------------------------------
// drb_ease
// Ease-in-out cubic, 100 * B(t), turned into the ramp fraction of full scale.
// ----------------------------------------------------------------------------
module drb_ease (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  drb_pkg::ctl_t             ctl_in,
	input  logic [drb_pkg::T_W-1:0]   t_in,
	output drb_pkg::ctl_t             ctl_out,
	output logic [drb_pkg::Q_W-1:0]   frac
);
	import drb_pkg::*;

	ctl_t           ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [T_W-1:0] t_s1, t_s2;
	logic [U_W-1:0] u_s1, u_s2;
	logic [T_W-1:0] t2_s2;
	logic [U_W-1:0] u2_s2;
	logic [T_W-1:0] t3_s3, ut_s3, ut2_s3;
	logic [P_W-1:0] poly_s4;
	logic [Q_W-1:0] frac_s5;

	logic [PR_W-1:0] tt_p, uu_p, t3_p, ut_p, ut2_p;
	logic [P_W-1:0]  capped;

	assign tt_p  = PR_W'(t_s1) * PR_W'(t_s1);
	assign uu_p  = PR_W'(u_s1) * PR_W'(u_s1);
	assign t3_p  = PR_W'(t2_s2) * PR_W'(t_s2);
	assign ut_p  = PR_W'(u2_s2) * PR_W'(t_s2);
	assign ut2_p = PR_W'(u_s2) * PR_W'(t2_s2);

	assign capped = (poly_s4 > P_W'(FULL_Q)) ? P_W'(FULL_Q) : poly_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, region: REGION_DARK};
			ctl_s2 <= '{valid: 1'b0, region: REGION_DARK};
			ctl_s3 <= '{valid: 1'b0, region: REGION_DARK};
			ctl_s4 <= '{valid: 1'b0, region: REGION_DARK};
			ctl_s5 <= '{valid: 1'b0, region: REGION_DARK};
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1          <= t_in;
			u_s1          <= ONE_Q - U_W'(t_in);

			t_s2          <= t_s1;
			u_s2          <= u_s1;
			t2_s2         <= tt_p[FRAC_BITS +: T_W];
			u2_s2         <= uu_p[FRAC_BITS +: U_W];

			t3_s3         <= t3_p[FRAC_BITS +: T_W];
			ut_s3         <= ut_p[FRAC_BITS +: T_W];
			ut2_s3        <= ut2_p[FRAC_BITS +: T_W];

			poly_s4       <= P_W'(ut_s3) * P_W'(W_RISE) + P_W'(ut2_s3) * P_W'(W_FALL)
			               + P_W'(t3_s3) * P_W'(W_CUBE);

			frac_s5       <= (ctl_s4.region == REGION_FALL) ? FULL_Q - Q_W'(capped)
			                                                : Q_W'(capped);
		end
	end

	assign ctl_out = ctl_s5;
	assign frac    = frac_s5;

endmodule

@@ rtl/core/drb_scale.sv @@
// ----------------------------------------------------------------------------
// drb_scale
// Per-channel scaling by the peak level, divide by 100, saturation and the
// output register.
// ----------------------------------------------------------------------------
module drb_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  drb_pkg::ctl_t               ctl_in,
	input  logic [drb_pkg::Q_W-1:0]     frac,
	input  drb_pkg::peaks_t             peaks,
	output logic                        out_valid,
	output drb_pkg::peaks_t             levels
);
	import drb_pkg::*;

	localparam int MP_W = Q_W + PCT_W;
	localparam int MD_W = X_W + RECIP_W;

	ctl_t           ctl_s1;
	logic [X_W-1:0] xw_s1, xb_s1, xu_s1;
	logic           valid_s2;
	peaks_t         levels_s2;

	logic [MP_W-1:0] pw_p, pb_p, pu_p;

	assign pw_p = MP_W'(frac) * MP_W'(peaks.white);
	assign pb_p = MP_W'(frac) * MP_W'(peaks.blue);
	assign pu_p = MP_W'(frac) * MP_W'(peaks.uv);

	function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
		sat_pct = (v > PCT_MAX) ? PCT_MAX : v;
	endfunction

	function automatic logic [PCT_W-1:0] level_of(
		input region_t          region,
		input logic [X_W-1:0]   x,
		input logic [PCT_W-1:0] peak
	);
		logic [MD_W-1:0] q;
		q = MD_W'(x) * MD_W'(RECIP);
		case (region)
			REGION_PEAK: level_of = sat_pct(peak);
			REGION_RISE,
			REGION_FALL: level_of = sat_pct(q[RECIP_SHIFT +: PCT_W]);
			default:     level_of = '0;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid  <= 1'b0;
			ctl_s1.region <= REGION_DARK;
			valid_s2      <= 1'b0;
		end else if (en) begin
			ctl_s1.valid  <= ctl_in.valid;
			ctl_s1.region <= ctl_in.region;
			valid_s2      <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xw_s1         <= pw_p[FRAC_BITS +: X_W];
			xb_s1         <= pb_p[FRAC_BITS +: X_W];
			xu_s1         <= pu_p[FRAC_BITS +: X_W];

			levels_s2.white <= level_of(ctl_s1.region, xw_s1, peaks.white);
			levels_s2.blue  <= level_of(ctl_s1.region, xb_s1, peaks.blue);
			levels_s2.uv    <= level_of(ctl_s1.region, xu_s1, peaks.uv);
		end
	end

	assign out_valid = valid_s2;
	assign levels    = levels_s2;

endmodule

@@ rtl/core/daylight_ramp_brightness.sv @@
// ----------------------------------------------------------------------------
// daylight_ramp_brightness
// Daylight schedule for three LED channels with eased sunrise and sunset.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         s_tvalid / s_tready      time of day request
//  m_axis    out        m_tvalid / m_tready      three channel levels
//  apb       in         psel / penable / pready  schedule and peak registers
//
// A request is accepted in every cycle in which the pipeline can move, and
// its levels are formed in order by the minute of day and schedule region
// stages, the one-bit-per-stage divider that forms the ramp progress, the
// stages of the easing cubic and the channel scaling stages, the last of
// which is the output register.
// Reset clears the valid bits of every stage and loads the register reset
// values. When a result waits in the output register and the receiver is
// not ready, the whole pipeline holds, so nothing is lost or repeated.
//
// The time of day is hour * 60 + minute. Outside the on to off window every
// level is zero, inside the peak window it is the channel peak, and on a
// ramp the peak is scaled by the Bezier ease-in-out curve B(t) on sunrise
// or by 1 - B(t) on sunset, where t is elapsed time over ramp length in
// unsigned fixed point. Levels are truncated and saturated to 100.
//
// The schedule registers are read directly by the pipeline, so they are to
// be written only while no request is in flight.
// ----------------------------------------------------------------------------
module daylight_ramp_brightness (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // hour [4:0], minute [10:5], zero [15:11]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // level_white [6:0], level_blue [13:7],
	                               // level_uv [20:14], zero [23:21]

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import drb_pkg::*;

	sched_t          sched_q;
	peaks_t          peaks_q;
	cfg_idx_t        cfg_idx;
	logic            cfg_write;

	logic            advance;
	ctl_t            sched_ctl, div_ctl, ease_ctl;
	logic [MIN_W-1:0] elapsed, span;
	logic [T_W-1:0]  progress;
	logic [Q_W-1:0]  frac;
	logic            out_valid;
	peaks_t          levels;

	// Register file. The word index comes from paddr[4:2]; index seven is not
	// a register, so writes to it are dropped and reads return zero.
	assign pready    = 1'b1;
	assign cfg_idx   = cfg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q.on_min     <= RST_ON;
			sched_q.peak_start <= RST_PEAK_START;
			sched_q.peak_end   <= RST_PEAK_END;
			sched_q.off_min    <= RST_OFF;
			peaks_q.white      <= RST_PEAK;
			peaks_q.blue       <= RST_PEAK;
			peaks_q.uv         <= RST_PEAK;
		end else if (cfg_write) begin
			case (cfg_idx)
				IDX_ON:         sched_q.on_min     <= pwdata[MIN_W-1:0];
				IDX_PEAK_START: sched_q.peak_start <= pwdata[MIN_W-1:0];
				IDX_PEAK_END:   sched_q.peak_end   <= pwdata[MIN_W-1:0];
				IDX_OFF:        sched_q.off_min    <= pwdata[MIN_W-1:0];
				IDX_PEAK_WHITE: peaks_q.white      <= pwdata[PCT_W-1:0];
				IDX_PEAK_BLUE:  peaks_q.blue       <= pwdata[PCT_W-1:0];
				IDX_PEAK_UV:    peaks_q.uv         <= pwdata[PCT_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			IDX_ON:         prdata = 32'(sched_q.on_min);
			IDX_PEAK_START: prdata = 32'(sched_q.peak_start);
			IDX_PEAK_END:   prdata = 32'(sched_q.peak_end);
			IDX_OFF:        prdata = 32'(sched_q.off_min);
			IDX_PEAK_WHITE: prdata = 32'(peaks_q.white);
			IDX_PEAK_BLUE:  prdata = 32'(peaks_q.blue);
			IDX_PEAK_UV:    prdata = 32'(peaks_q.uv);
			default:        prdata = '0;
		endcase
	end

	// All stages move together. They may move whenever the output register
	// is empty or its result is being taken in this cycle.
	assign advance  = !out_valid || m_tready;
	assign s_tready = advance;

	drb_sched u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (s_tvalid),
		.hour     (s_tdata[HOUR_W-1:0]),
		.minute   (s_tdata[HOUR_W +: MINUTE_W]),
		.sched    (sched_q),
		.ctl      (sched_ctl),
		.elapsed  (elapsed),
		.span     (span)
	);

	drb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ctl_in   (sched_ctl),
		.elapsed  (elapsed),
		.span     (span),
		.ctl_out  (div_ctl),
		.quot     (progress)
	);

	drb_ease u_ease (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ctl_in   (div_ctl),
		.t_in     (progress),
		.ctl_out  (ease_ctl),
		.frac     (frac)
	);

	drb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.ctl_in    (ease_ctl),
		.frac      (frac),
		.peaks     (peaks_q),
		.out_valid (out_valid),
		.levels    (levels)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {3'b000, levels.uv, levels.blue, levels.white};

endmodule
